// File: rtl/core/eth_ipv4_receive_classifier_assert.svh
// ----------------------------------------------------------------------------
// eth_ipv4_receive_classifier assertion macros
// shared property forms for the classifier checks, clocked on clk, off in reset
// ----------------------------------------------------------------------------
`ifndef ETH_IPV4_RECEIVE_CLASSIFIER_ASSERT_SVH
`define ETH_IPV4_RECEIVE_CLASSIFIER_ASSERT_SVH

// condition implies consequence in the same cycle
`define ERC_ASSERT_SAME(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("classifier check failed in the same cycle");

// condition implies consequence in the next cycle
`define ERC_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("classifier check failed one cycle later");

`endif

// File: rtl/core/erc_pkg.sv
// ----------------------------------------------------------------------------
// erc_pkg
// types, codes and helpers shared by the ethernet/ipv4 receive classifier
// ----------------------------------------------------------------------------
package erc_pkg;

  localparam int MAX_FRAME_DEF = 2048;

  // header checksum sum covers at most 30 words of 16 bits
  localparam int IP_SUM_W = 21;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 64;

  // register index is paddr bit 3 (8 byte spacing)
  localparam logic REG_LOCAL_MAC = 1'b0;
  localparam logic REG_LOCAL_IP  = 1'b1;

  localparam logic [15:0] ETYPE_ARP  = 16'h0806;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  typedef enum logic [3:0] {
    VD_SHORT       = 4'd0,
    VD_MAC_MISS    = 4'd1,
    VD_ARP         = 4'd2,
    VD_BAD_IP_HDR  = 4'd3,
    VD_BAD_IP_CSUM = 4'd4,
    VD_IP_MISS     = 4'd5,
    VD_ICMP        = 4'd6,
    VD_UDP         = 4'd7,
    VD_UDP_DROP    = 4'd8,
    VD_TCP         = 4'd9,
    VD_TCP_REJECT  = 4'd10,
    VD_OTHER_TYPE  = 4'd11,
    VD_OTHER_PROTO = 4'd12
  } erc_verdict_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } erc_in_t;

  typedef struct packed {
    logic [3:0]  verdict;
    logic [31:0] source_ip;
    logic [15:0] source_port;
    logic [11:0] udp_data_len;
    logic [5:0]  ip_header_len;
    logic [11:0] ip_body_len;
    logic [11:0] frame_len;
  } erc_out_t;

  // frame state captured at the last byte
  typedef struct packed {
    logic [1:0]          mac_flags;
    logic [15:0]         ethertype;
    logic [3:0]          hdr_words;
    logic [7:0]          protocol;
    logic [15:0]         ip_csum;
    logic [IP_SUM_W-1:0] ip_sum;
    logic [31:0]         src_addr;
    logic [1:0]          ip_flags;
    logic [15:0]         tcp_csum;
    logic [15:0]         udp_port;
    logic [15:0]         udp_len;
    logic [7:0]          pending;
  } erc_snap_t;

  // ones' complement fold of a 32 bit sum, then invert
  function automatic logic [15:0] fold_inv(input logic [31:0] s);
    logic [16:0] a;
    logic [16:0] c;
    a = {1'b0, s[15:0]} + {1'b0, s[31:16]};
    c = {1'b0, a[15:0]} + {16'h0000, a[16]};
    return ~c[15:0];
  endfunction

endpackage

// File: rtl/core/eth_ipv4_receive_classifier.sv
// ----------------------------------------------------------------------------
// eth_ipv4_receive_classifier
// receive-side frame filter: mac, ethertype, ipv4 header, udp and tcp checks
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle with a last-byte mark and gives one verdict
// word per frame. Bytes are taken back to back at one per cycle while in_stall
// is low: each byte passes an input register and then updates counters, match
// flags and the two checksum sums. At the last byte the frame state is
// captured and the verdict is worked out from that capture into the output
// register. in_stall rises only when a frame ends while the previous frame's
// capture and the output register are both held by out_stall. Bytes past
// MAX_FRAME are ignored. local_mac and local_ip sit at byte addresses 0 and 8
// of the apb port. They are to be written by the user only while no frame is in
// flight; the block itself does not enforce this.
module eth_ipv4_receive_classifier #(
  parameter int MAX_FRAME = erc_pkg::MAX_FRAME_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  erc_pkg::erc_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output erc_pkg::erc_out_t           out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [erc_pkg::PADDR_W-1:0] paddr,
  input  logic [erc_pkg::PDATA_W-1:0] pwdata,
  output logic [erc_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int CNT_W = $clog2(MAX_FRAME + 1);
  localparam int SUM_W = CNT_W + 16;

  logic [47:0]        local_mac;
  logic [31:0]        local_ip;
  logic               snap_valid;
  logic               snap_ready;
  erc_pkg::erc_snap_t snap;
  logic [CNT_W-1:0]   snap_len;
  logic [SUM_W-1:0]   snap_tcp_sum;

  erc_cfg_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .local_mac (local_mac),
    .local_ip  (local_ip)
  );

  erc_parse #(
    .MAX_FRAME (MAX_FRAME),
    .CNT_W     (CNT_W),
    .SUM_W     (SUM_W)
  ) u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .local_mac    (local_mac),
    .local_ip     (local_ip),
    .snap_ready   (snap_ready),
    .snap_valid   (snap_valid),
    .snap         (snap),
    .snap_len     (snap_len),
    .snap_tcp_sum (snap_tcp_sum)
  );

  erc_verdict #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_verdict (
    .clk          (clk),
    .rst_n        (rst_n),
    .snap_valid   (snap_valid),
    .snap_ready   (snap_ready),
    .snap         (snap),
    .snap_len     (snap_len),
    .snap_tcp_sum (snap_tcp_sum),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

`include "eth_ipv4_receive_classifier_assert.svh"

  // input backs up only behind a held capture and a held result
  `ERC_ASSERT_SAME(a_stall_cause, in_stall, snap_valid && out_valid && out_stall)
  // a capture taken by the verdict stage shows up as a result
  `ERC_ASSERT_NEXT(a_capture_to_out, snap_valid && snap_ready, out_valid)
  `ERC_ASSERT_SAME(a_verdict_range, out_valid, out_data.verdict <= erc_pkg::VD_OTHER_PROTO)
  // port and data length only carry meaning for a delivered udp datagram
  `ERC_ASSERT_SAME(a_udp_fields, out_valid && out_data.verdict != erc_pkg::VD_UDP,
                   out_data.source_port == 16'h0000 && out_data.udp_data_len == 12'h000)

endmodule

// File: rtl/core/erc_cfg_regs.sv
// ----------------------------------------------------------------------------
// erc_cfg_regs
// apb register file holding the local mac and ip addresses
// ----------------------------------------------------------------------------
module erc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [erc_pkg::PADDR_W-1:0] paddr,
  input  logic [erc_pkg::PDATA_W-1:0] pwdata,
  output logic [erc_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output logic [47:0]                 local_mac,
  output logic [31:0]                 local_ip
);

  logic [47:0] local_mac_r;
  logic [31:0] local_ip_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_mac_r <= '0;
      local_ip_r  <= '0;
    end else if (wr_en) begin
      unique case (paddr[3])
        erc_pkg::REG_LOCAL_MAC: local_mac_r <= pwdata[47:0];
        erc_pkg::REG_LOCAL_IP:  local_ip_r  <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      erc_pkg::REG_LOCAL_MAC: prdata = {16'h0000, local_mac_r};
      erc_pkg::REG_LOCAL_IP:  prdata = {32'h0000_0000, local_ip_r};
      default:                prdata = '0;
    endcase
  end

  assign local_mac = local_mac_r;
  assign local_ip  = local_ip_r;

endmodule

// File: rtl/core/erc_parse.sv
// ----------------------------------------------------------------------------
// erc_parse
// input byte register and per-byte header tracking; captures frame state at end
// ----------------------------------------------------------------------------
module erc_parse #(
  parameter int MAX_FRAME = erc_pkg::MAX_FRAME_DEF,
  parameter int CNT_W     = $clog2(MAX_FRAME + 1),
  parameter int SUM_W     = CNT_W + 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  erc_pkg::erc_in_t  in_data,
  input  logic [47:0]       local_mac,
  input  logic [31:0]       local_ip,
  input  logic              snap_ready,
  output logic              snap_valid,
  output erc_pkg::erc_snap_t snap,
  output logic [CNT_W-1:0]  snap_len,
  output logic [SUM_W-1:0]  snap_tcp_sum
);

  localparam int IW = erc_pkg::IP_SUM_W;

  erc_pkg::erc_in_t   inq_r;
  logic               inq_valid_r;
  logic               accept;
  logic               consume;
  logic               frame_end;

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [1:0]         macf_r, macf_nxt;
  logic [15:0]        eth_r, eth_nxt;
  logic [3:0]         hw_r, hw_nxt;
  logic [7:0]         proto_r, proto_nxt;
  logic [15:0]        ipcs_r, ipcs_nxt;
  logic [IW-1:0]      ipsum_r, ipsum_nxt;
  logic [31:0]        src_r, src_nxt;
  logic [1:0]         ipf_r, ipf_nxt;
  logic [SUM_W-1:0]   tcpsum_r, tcpsum_nxt;
  logic [15:0]        tcpcs_r, tcpcs_nxt;
  logic [15:0]        uport_r, uport_nxt;
  logic [15:0]        ulen_r, ulen_nxt;
  logic [7:0]         pend_r, pend_nxt;

  erc_pkg::erc_snap_t snap_r, snap_nxt;
  logic               snap_valid_r;
  logic [CNT_W-1:0]   snap_len_r;
  logic [SUM_W-1:0]   snap_tcp_sum_r;

  logic [7:0]         b;
  logic [CNT_W-1:0]   o;
  logic [CNT_W-1:0]   t;
  logic [3:0]         hw_cur;
  logic [5:0]         hdr;
  logic [15:0]        word;
  logic [7:0]         mac_byte;
  logic [7:0]         ip_byte;

  // a frame end can only leave when the capture slot is free
  assign consume   = inq_valid_r & (~inq_r.last_byte | ~snap_valid_r | snap_ready);
  assign in_stall  = inq_valid_r & ~consume;
  assign accept    = in_valid & ~in_stall;
  assign frame_end = consume & inq_r.last_byte;

  assign b      = inq_r.frame_byte;
  assign o      = cnt_r - CNT_W'(14);
  assign hw_cur = (cnt_r == CNT_W'(14)) ? b[3:0] : hw_r;
  assign hdr    = {hw_cur, 2'b00};
  assign t      = o - CNT_W'(hdr);

  always_comb begin
    case (cnt_r[2:0])
      3'd0:    mac_byte = local_mac[47:40];
      3'd1:    mac_byte = local_mac[39:32];
      3'd2:    mac_byte = local_mac[31:24];
      3'd3:    mac_byte = local_mac[23:16];
      3'd4:    mac_byte = local_mac[15:8];
      3'd5:    mac_byte = local_mac[7:0];
      default: mac_byte = 8'h00;
    endcase
  end

  always_comb begin
    case (o[1:0])
      2'd0:    ip_byte = local_ip[31:24];
      2'd1:    ip_byte = local_ip[23:16];
      2'd2:    ip_byte = local_ip[15:8];
      default: ip_byte = local_ip[7:0];
    endcase
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    macf_nxt   = macf_r;
    eth_nxt    = eth_r;
    hw_nxt     = hw_r;
    proto_nxt  = proto_r;
    ipcs_nxt   = ipcs_r;
    ipsum_nxt  = ipsum_r;
    src_nxt    = src_r;
    ipf_nxt    = ipf_r;
    tcpsum_nxt = tcpsum_r;
    tcpcs_nxt  = tcpcs_r;
    uport_nxt  = uport_r;
    ulen_nxt   = ulen_r;
    pend_nxt   = pend_r;
    word       = '0;
    // bytes past the frame limit are dropped
    if (cnt_r < CNT_W'(MAX_FRAME)) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r < CNT_W'(6)) begin
        if (b != mac_byte) macf_nxt[0] = 1'b0;
        if (b != 8'hFF)    macf_nxt[1] = 1'b0;
      end else if (cnt_r < CNT_W'(14)) begin
        if (cnt_r >= CNT_W'(12)) eth_nxt = {eth_r[7:0], b};
      end else begin
        hw_nxt = hw_cur;
        if (o == CNT_W'(9)) proto_nxt = b;
        if (o == CNT_W'(10) || o == CNT_W'(11)) ipcs_nxt = {ipcs_r[7:0], b};
        if (o >= CNT_W'(12) && o < CNT_W'(16)) src_nxt = {src_r[23:0], b};
        if (o >= CNT_W'(16) && o < CNT_W'(20)) begin
          if (b != ip_byte) ipf_nxt[0] = 1'b0;
          if (b != 8'hFF)   ipf_nxt[1] = 1'b0;
        end
        if (o < CNT_W'(hdr)) begin
          // checksum field itself is summed as zero
          if (!o[0]) begin
            pend_nxt = (o == CNT_W'(10)) ? 8'h00 : b;
          end else begin
            word      = {pend_r, (o == CNT_W'(11)) ? 8'h00 : b};
            ipsum_nxt = ipsum_r + IW'(word);
            // source and destination address feed the pseudo-header
            if (o >= CNT_W'(12) && o < CNT_W'(20)) tcpsum_nxt = tcpsum_r + SUM_W'(word);
          end
        end else if (hdr >= 6'd20) begin
          if (t < CNT_W'(2)) uport_nxt = {uport_r[7:0], b};
          if (t == CNT_W'(4) || t == CNT_W'(5)) ulen_nxt = {ulen_r[7:0], b};
          if (t == CNT_W'(16) || t == CNT_W'(17)) tcpcs_nxt = {tcpcs_r[7:0], b};
          if (!t[0]) begin
            pend_nxt = (t == CNT_W'(16)) ? 8'h00 : b;
          end else begin
            word       = {pend_r, (t == CNT_W'(17)) ? 8'h00 : b};
            tcpsum_nxt = tcpsum_r + SUM_W'(word);
          end
        end
      end
    end
  end

  assign snap_nxt = '{
    mac_flags: macf_nxt,
    ethertype: eth_nxt,
    hdr_words: hw_nxt,
    protocol:  proto_nxt,
    ip_csum:   ipcs_nxt,
    ip_sum:    ipsum_nxt,
    src_addr:  src_nxt,
    ip_flags:  ipf_nxt,
    tcp_csum:  tcpcs_nxt,
    udp_port:  uport_nxt,
    udp_len:   ulen_nxt,
    pending:   pend_nxt
  };

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r  <= 1'b0;
      snap_valid_r <= 1'b0;
      cnt_r        <= '0;
      macf_r       <= 2'b11;
      eth_r        <= '0;
      hw_r         <= '0;
      proto_r      <= '0;
      ipcs_r       <= '0;
      ipsum_r      <= '0;
      src_r        <= '0;
      ipf_r        <= 2'b11;
      tcpsum_r     <= '0;
      tcpcs_r      <= '0;
      uport_r      <= '0;
      ulen_r       <= '0;
      pend_r       <= '0;
    end else begin
      if (accept) begin
        inq_valid_r <= 1'b1;
      end else if (consume) begin
        inq_valid_r <= 1'b0;
      end
      if (frame_end) begin
        snap_valid_r <= 1'b1;
      end else if (snap_ready) begin
        snap_valid_r <= 1'b0;
      end
      if (frame_end) begin
        cnt_r    <= '0;
        macf_r   <= 2'b11;
        eth_r    <= '0;
        hw_r     <= '0;
        proto_r  <= '0;
        ipcs_r   <= '0;
        ipsum_r  <= '0;
        src_r    <= '0;
        ipf_r    <= 2'b11;
        tcpsum_r <= '0;
        tcpcs_r  <= '0;
        uport_r  <= '0;
        ulen_r   <= '0;
        pend_r   <= '0;
      end else if (consume) begin
        cnt_r    <= cnt_nxt;
        macf_r   <= macf_nxt;
        eth_r    <= eth_nxt;
        hw_r     <= hw_nxt;
        proto_r  <= proto_nxt;
        ipcs_r   <= ipcs_nxt;
        ipsum_r  <= ipsum_nxt;
        src_r    <= src_nxt;
        ipf_r    <= ipf_nxt;
        tcpsum_r <= tcpsum_nxt;
        tcpcs_r  <= tcpcs_nxt;
        uport_r  <= uport_nxt;
        ulen_r   <= ulen_nxt;
        pend_r   <= pend_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      inq_r <= in_data;
    end
    if (frame_end) begin
      snap_r         <= snap_nxt;
      snap_len_r     <= cnt_nxt;
      snap_tcp_sum_r <= tcpsum_nxt;
    end
  end

  assign snap_valid   = snap_valid_r;
  assign snap         = snap_r;
  assign snap_len     = snap_len_r;
  assign snap_tcp_sum = snap_tcp_sum_r;

endmodule

// File: rtl/core/erc_verdict.sv
// ----------------------------------------------------------------------------
// erc_verdict
// turns captured frame state into a verdict word held in the output register
// ----------------------------------------------------------------------------
module erc_verdict #(
  parameter int CNT_W = $clog2(erc_pkg::MAX_FRAME_DEF + 1),
  parameter int SUM_W = CNT_W + 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               snap_valid,
  output logic               snap_ready,
  input  erc_pkg::erc_snap_t snap,
  input  logic [CNT_W-1:0]   snap_len,
  input  logic [SUM_W-1:0]   snap_tcp_sum,
  output logic               out_valid,
  input  logic               out_stall,
  output erc_pkg::erc_out_t  out_data
);

  localparam int SW = SUM_W + 1;

  logic              out_valid_r;
  erc_pkg::erc_out_t out_r, res;
  logic              load;

  logic [5:0]        hdr;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  ipp;
  logic [SW-1:0]     tcp_s;
  logic [15:0]       udp_a;
  logic [15:0]       udp_room;
  logic [15:0]       udp_min;
  logic              ip_csum_ok;
  logic              tcp_csum_ok;

  assign snap_ready = ~out_valid_r | ~out_stall;
  assign load       = snap_valid & snap_ready;

  assign hdr      = {snap.hdr_words, 2'b00};
  assign rem      = snap_len - CNT_W'(14);
  assign ipp      = rem - CNT_W'(hdr);
  assign udp_a    = snap.udp_len - 16'd8;
  assign udp_room = 16'(ipp) - 16'd8;
  assign udp_min  = (udp_a > udp_room) ? udp_room : udp_a;

  // pseudo-header: protocol and segment length, odd tail byte padded
  assign tcp_s = SW'(snap_tcp_sum) + SW'(erc_pkg::PROTO_TCP) + SW'(ipp)
               + (ipp[0] ? SW'({snap.pending, 8'h00}) : SW'(0));

  assign ip_csum_ok  = erc_pkg::fold_inv(32'(snap.ip_sum)) == snap.ip_csum;
  assign tcp_csum_ok = erc_pkg::fold_inv(32'(tcp_s)) == snap.tcp_csum;

  always_comb begin
    res           = '0;
    res.frame_len = 12'(snap_len);
    if (snap_len < CNT_W'(14)) begin
      res.verdict = erc_pkg::VD_SHORT;
    end else if (snap.mac_flags == 2'b00) begin
      res.verdict = erc_pkg::VD_MAC_MISS;
    end else if (snap.ethertype == erc_pkg::ETYPE_ARP) begin
      res.verdict = erc_pkg::VD_ARP;
    end else if (snap.ethertype != erc_pkg::ETYPE_IPV4) begin
      res.verdict = erc_pkg::VD_OTHER_TYPE;
    end else if (rem < CNT_W'(20) || snap.hdr_words < 4'd5 || rem < CNT_W'(hdr)) begin
      res.verdict = erc_pkg::VD_BAD_IP_HDR;
    end else begin
      res.source_ip     = snap.src_addr;
      res.ip_header_len = hdr;
      res.ip_body_len   = 12'(ipp);
      if (!ip_csum_ok) begin
        res.verdict = erc_pkg::VD_BAD_IP_CSUM;
      end else if (snap.ip_flags == 2'b00) begin
        res.verdict = erc_pkg::VD_IP_MISS;
      end else if (snap.protocol == erc_pkg::PROTO_ICMP) begin
        res.verdict = erc_pkg::VD_ICMP;
      end else if (snap.protocol == erc_pkg::PROTO_UDP) begin
        // both the stated and the present data length must be positive
        if (ipp > CNT_W'(8) && snap.udp_len > 16'd8) begin
          res.verdict      = erc_pkg::VD_UDP;
          res.udp_data_len = udp_min[11:0];
          res.source_port  = snap.udp_port;
        end else begin
          res.verdict = erc_pkg::VD_UDP_DROP;
        end
      end else if (snap.protocol == erc_pkg::PROTO_TCP) begin
        if (ipp < CNT_W'(20) || !tcp_csum_ok) begin
          res.verdict = erc_pkg::VD_TCP_REJECT;
        end else begin
          res.verdict = erc_pkg::VD_TCP;
        end
      end else begin
        res.verdict = erc_pkg::VD_OTHER_PROTO;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
